// ----- rtl/expression_tokenizer_top_assert.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef EXPRESSION_TOKENIZER_TOP_ASSERT_SVH
`define EXPRESSION_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ET_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("tokenizer assertion failed");
`define ET_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");
`define ET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");
`else
`define ET_ASSERT(lbl, clk, rstn, prop)
`define ET_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ET_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/exptok_pkg.sv -----
`timescale 1ns / 1ps
package exptok_pkg;

	localparam int unsigned MAX_CHARS  = 4096;
	localparam int unsigned FIELD_LIM  = 4096;
	localparam int unsigned POS_LIMIT  = (MAX_CHARS < FIELD_LIM) ? MAX_CHARS : FIELD_LIM;
	localparam int unsigned CHAR_W     = 16;
	localparam int unsigned POS_W      = 12;
	localparam int unsigned IDX_W      = 13;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int unsigned N_OP  = 20;
	localparam int unsigned N_BR  = 6;
	localparam int unsigned N_SYM = 25;

	localparam logic [CHAR_W-1:0] OP_SET [N_OP] = '{
		16'h002B, 16'h002D, 16'h002A, 16'h002F, 16'h005E, 16'h0021, 16'h003C,
		16'h003E, 16'h003D, 16'h007C, 16'h0026, 16'h0025, 16'h002C, 16'h003B,
		16'h007E, 16'h003A, 16'h005F, 16'h2260, 16'h2264, 16'h2265
	};

	localparam logic [CHAR_W-1:0] BR_SET [N_BR] = '{
		16'h0028, 16'h0029, 16'h005B, 16'h005D, 16'h007B, 16'h007D
	};

	localparam logic [CHAR_W-1:0] SYM_SET [N_SYM] = '{
		16'h221E, 16'h03B1, 16'h03B2, 16'h03B3, 16'h03B4, 16'h03B5, 16'h03B6,
		16'h03B7, 16'h03B8, 16'h03B9, 16'h03BA, 16'h039B, 16'h03BC, 16'h03BD,
		16'h03BE, 16'h03BF, 16'h03C0, 16'h03C1, 16'h03C3, 16'h03C4, 16'h03C5,
		16'h03C6, 16'h03C7, 16'h03C8, 16'h03C9
	};

	localparam logic [CHAR_W-1:0] CH_NUL   = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_APOS  = 16'h0027;

	typedef enum logic [2:0] {
		CLS_NUM,
		CLS_NAME,
		CLS_OP,
		CLS_BRACKET,
		CLS_SYMBOL,
		CLS_BLANK,
		CLS_UNKNOWN
	} cls_t;

	typedef enum logic [1:0] {
		ST_TOKEN,
		ST_END,
		ST_UNKNOWN,
		ST_TOO_LONG
	} status_t;

	typedef enum logic [2:0] {
		KIND_NUM,
		KIND_NAME,
		KIND_OP,
		KIND_BRACKET,
		KIND_SYMBOL
	} kind_t;

	typedef enum logic [1:0] {
		RUN_NONE,
		RUN_NUM,
		RUN_NAME
	} run_mode_t;

	typedef struct packed {
		status_t          status;
		kind_t            kind;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
	} tok_res_t;

	typedef struct packed {
		logic     two;
		tok_res_t r0;
		tok_res_t r1;
	} tok_entry_t;

	function automatic cls_t classify(input logic [CHAR_W-1:0] c);
		logic is_op;
		logic is_br;
		logic is_sym;
		cls_t cls;
		is_op  = 1'b0;
		is_br  = 1'b0;
		is_sym = 1'b0;
		for (int i = 0; i < N_OP; i++)
			if (c == OP_SET[i]) is_op = 1'b1;
		for (int i = 0; i < N_BR; i++)
			if (c == BR_SET[i]) is_br = 1'b1;
		for (int i = 0; i < N_SYM; i++)
			if (c == SYM_SET[i]) is_sym = 1'b1;
		priority if ((c >= 16'h0030 && c <= 16'h0039) || c == CH_DOT) cls = CLS_NUM;
		else if (is_sym) cls = CLS_SYMBOL;
		else if ((c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A)
				|| c == CH_APOS) cls = CLS_NAME;
		else if (is_op) cls = CLS_OP;
		else if (is_br) cls = CLS_BRACKET;
		else if (c == CH_NUL || c == CH_SPACE || c == CH_TAB) cls = CLS_BLANK;
		else cls = CLS_UNKNOWN;
		return cls;
	endfunction

endpackage

// ----- rtl/exptok_char_if.sv -----
`timescale 1ns / 1ps
interface exptok_char_if import exptok_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// ----- rtl/exptok_tok_if.sv -----
`timescale 1ns / 1ps
interface exptok_tok_if import exptok_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [2:0]       token_kind;
	logic [POS_W-1:0] start_pos;
	logic [POS_W-1:0] token_len;
	logic             last;

	modport source (output valid, output status, output token_kind, output start_pos,
		output token_len, output last, input ready);
	modport sink (input valid, input status, input token_kind, input start_pos,
		input token_len, input last, output ready);
endinterface

// ----- rtl/expression_tokenizer_top.sv -----
`timescale 1ns / 1ps
// Expression tokenizer: accepts one UTF-16 character per cycle while the queue
// has room and emits tokens (kind, start index, length), end markers and error
// beats, one result beat per cycle while the receiver is ready; each result goes
// through the queue and then the output register. Input acceptance is limited
// only by the 4-entry queue between the classifier and the output register; a
// character that closes a run and is a single-character token or the expression
// end yields two beats, sent one after the other, so the sustained rate is one
// character per cycle except where such pairs or receiver stalls fill the queue.
module expression_tokenizer_top import exptok_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	exptok_char_if.sink  char_in,
	exptok_tok_if.source tok_out
);

	logic       q_ready;
	logic       push;
	tok_entry_t push_entry;
	logic       pop;
	logic       head_valid;
	tok_entry_t head;

	exptok_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	exptok_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	exptok_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tok_out    (tok_out)
	);

endmodule

// ----- rtl/exptok_front.sv -----
`timescale 1ns / 1ps
module exptok_front import exptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	exptok_char_if.sink char_in,
	input  logic       q_ready,
	output logic       push,
	output tok_entry_t push_entry
);

	run_mode_t        run_mode_q, run_mode_d;
	logic [POS_W-1:0] run_start_q, run_start_d;
	logic [IDX_W-1:0] next_index_q, next_index_d;

	logic             acc;
	cls_t             cls;
	logic [IDX_W-1:0] idx;
	logic [POS_W-1:0] pos;
	logic             run_emit;
	logic             one_emit;
	tok_res_t         run_res;
	tok_res_t         one_res;

	assign char_in.ready = q_ready;
	assign acc = char_in.valid && q_ready;
	assign idx = next_index_q;
	assign pos = idx[POS_W-1:0];
	assign cls = classify(char_in.char_code);

	always_comb begin
		run_mode_d   = run_mode_q;
		run_start_d  = run_start_q;
		next_index_d = idx + IDX_W'(1);
		run_emit     = 1'b0;
		one_emit     = 1'b0;
		run_res      = '{ST_TOKEN, KIND_NUM, run_start_q, pos - run_start_q};
		one_res      = '{ST_TOKEN, KIND_NUM, pos, '0};
		if (run_mode_q == RUN_NAME) run_res.kind = KIND_NAME;

		if (idx >= IDX_W'(POS_LIMIT)) begin
			one_emit     = 1'b1;
			one_res      = '{ST_TOO_LONG, KIND_NUM, '0, '0};
			run_mode_d   = RUN_NONE;
			run_start_d  = '0;
			next_index_d = '0;
		end else if (cls == CLS_UNKNOWN) begin
			one_emit     = 1'b1;
			one_res      = '{ST_UNKNOWN, KIND_NUM, pos, '0};
			run_mode_d   = RUN_NONE;
			run_start_d  = '0;
			next_index_d = '0;
		end else if (run_mode_q != RUN_NONE && (cls == CLS_NUM || cls == CLS_NAME)) begin
			// run continues
		end else begin
			run_emit   = (run_mode_q != RUN_NONE);
			run_mode_d = RUN_NONE;
			unique case (cls)
				CLS_NUM: begin
					run_mode_d  = RUN_NUM;
					run_start_d = pos;
				end
				CLS_NAME: begin
					run_mode_d  = RUN_NAME;
					run_start_d = pos;
				end
				CLS_OP: begin
					one_emit = 1'b1;
					one_res  = '{ST_TOKEN, KIND_OP, pos, POS_W'(1)};
				end
				CLS_BRACKET: begin
					one_emit = 1'b1;
					one_res  = '{ST_TOKEN, KIND_BRACKET, pos, POS_W'(1)};
				end
				CLS_SYMBOL: begin
					one_emit = 1'b1;
					one_res  = '{ST_TOKEN, KIND_SYMBOL, pos, POS_W'(1)};
				end
				default: begin
					if (char_in.char_code == CH_NUL) begin
						one_emit     = 1'b1;
						one_res      = '{ST_END, KIND_NUM, pos, '0};
						run_start_d  = '0;
						next_index_d = '0;
					end
				end
			endcase
		end
	end

	always_comb begin
		push             = acc && (run_emit || one_emit);
		push_entry.two   = run_emit && one_emit;
		push_entry.r0    = run_emit ? run_res : one_res;
		push_entry.r1    = one_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q   <= RUN_NONE;
			run_start_q  <= '0;
			next_index_q <= '0;
		end else if (acc) begin
			run_mode_q   <= run_mode_d;
			run_start_q  <= run_start_d;
			next_index_q <= next_index_d;
		end
	end

endmodule

// ----- rtl/exptok_fifo.sv -----
`timescale 1ns / 1ps
`include "expression_tokenizer_top_assert.svh"
module exptok_fifo import exptok_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tok_entry_t push_entry,
	output logic       not_full,
	input  logic       pop,
	output logic       head_valid,
	output tok_entry_t head
);

	tok_entry_t         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign not_full   = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rptr_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + FIFO_AW'(1);
			if (do_pop) rptr_q <= rptr_q + FIFO_AW'(1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (FIFO_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (FIFO_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ET_ASSERT(a_cnt_max, clk, arst_n, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
	`ET_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, head_valid)
	`ET_ASSERT_NEXT(a_cnt_up, clk, arst_n, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1)
	`ET_ASSERT_IMPL(a_ptr_gap, clk, arst_n, cnt_q == '0 || cnt_q == (FIFO_AW+1)'(FIFO_DEPTH),
		wptr_q == rptr_q)

endmodule

// ----- rtl/exptok_back.sv -----
`timescale 1ns / 1ps
`include "expression_tokenizer_top_assert.svh"
module exptok_back import exptok_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  tok_entry_t  head,
	output logic        pop,
	exptok_tok_if.source tok_out
);

	logic     out_valid_q;
	logic     second_q;
	tok_res_t res_q;
	logic     last_q;

	logic     take;
	logic     fin;
	tok_res_t sel;

	assign take = !out_valid_q || tok_out.ready;
	assign fin  = second_q || !head.two;
	assign sel  = second_q ? head.r1 : head.r0;
	assign pop  = take && head_valid && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (take) begin
			out_valid_q <= head_valid;
			if (head_valid) second_q <= !fin;
		end
	end

	always_ff @(posedge clk) begin
		if (take && head_valid) begin
			res_q  <= sel;
			last_q <= fin;
		end
	end

	assign tok_out.valid      = out_valid_q;
	assign tok_out.status     = res_q.status;
	assign tok_out.token_kind = res_q.kind;
	assign tok_out.start_pos  = res_q.start;
	assign tok_out.token_len  = res_q.len;
	assign tok_out.last       = last_q;

	`ET_ASSERT_IMPL(a_second_has_pair, clk, arst_n, second_q, head_valid && head.two)
	`ET_ASSERT_IMPL(a_err_is_last, clk, arst_n, out_valid_q && res_q.status != ST_TOKEN,
		last_q && res_q.kind == KIND_NUM && res_q.len == '0)
	`ET_ASSERT_NEXT(a_first_not_last, clk, arst_n, take && head_valid && !fin,
		out_valid_q && !last_q && second_q)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb import exptok_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_CHARS = 855;

	typedef struct packed {
		status_t          status;
		kind_t            kind;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
		logic             last;
	} tok_exp_t;

	logic clk;
	logic arst_n;

	exptok_char_if char_bus ();
	exptok_tok_if  tok_bus ();

	expression_tokenizer_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_bus),
		.tok_out (tok_bus)
	);

	tok_exp_t         pending_tokens [$];
	tok_exp_t         want;
	run_mode_t        lex_run;
	logic [POS_W-1:0] lex_run_start;
	logic [IDX_W-1:0] lex_next_pos;

	int tx_idle;
	int rx_idle;
	int hold_requests;
	int hold_served;
	int hold_left;
	int chars_sent;
	int fail_cnt;
	int cycle_cnt;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic cls_t char_class(input logic [CHAR_W-1:0] c);
		bit in_op;
		bit in_br;
		bit in_sym;
		in_op  = 1'b0;
		in_br  = 1'b0;
		in_sym = 1'b0;
		for (int i = 0; i < N_OP; i++)
			in_op |= (OP_SET[i] == c);
		for (int i = 0; i < N_BR; i++)
			in_br |= (BR_SET[i] == c);
		for (int i = 0; i < N_SYM; i++)
			in_sym |= (SYM_SET[i] == c);
		if ((c >= "0" && c <= "9") || c == CH_DOT)
			return CLS_NUM;
		if (in_sym)
			return CLS_SYMBOL;
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_APOS)
			return CLS_NAME;
		if (in_op)
			return CLS_OP;
		if (in_br)
			return CLS_BRACKET;
		if (c == CH_NUL || c == CH_SPACE || c == CH_TAB)
			return CLS_BLANK;
		return CLS_UNKNOWN;
	endfunction

	task automatic lex_char(input logic [CHAR_W-1:0] c);
		tok_exp_t         res [2];
		int               n;
		cls_t             k;
		logic [IDX_W-1:0] idx;
		logic             clear;
		n     = 0;
		clear = 1'b0;
		idx   = lex_next_pos;
		k     = char_class(c);
		if (idx >= POS_LIMIT) begin
			res[0] = '{ST_TOO_LONG, KIND_NUM, '0, '0, 1'b0};
			n      = 1;
			clear  = 1'b1;
		end else if (k == CLS_UNKNOWN) begin
			res[0] = '{ST_UNKNOWN, KIND_NUM, idx[POS_W-1:0], '0, 1'b0};
			n      = 1;
			clear  = 1'b1;
		end else if (lex_run != RUN_NONE && (k == CLS_NUM || k == CLS_NAME)) begin
			lex_next_pos = idx + 1'b1;
		end else begin
			if (lex_run != RUN_NONE) begin
				res[n] = '{ST_TOKEN, (lex_run == RUN_NUM) ? KIND_NUM : KIND_NAME,
					lex_run_start, idx[POS_W-1:0] - lex_run_start, 1'b0};
				n++;
				lex_run = RUN_NONE;
			end
			case (k)
				CLS_NUM: begin
					lex_run       = RUN_NUM;
					lex_run_start = idx[POS_W-1:0];
				end
				CLS_NAME: begin
					lex_run       = RUN_NAME;
					lex_run_start = idx[POS_W-1:0];
				end
				CLS_OP: begin
					res[n] = '{ST_TOKEN, KIND_OP, idx[POS_W-1:0], 12'd1, 1'b0};
					n++;
				end
				CLS_BRACKET: begin
					res[n] = '{ST_TOKEN, KIND_BRACKET, idx[POS_W-1:0], 12'd1, 1'b0};
					n++;
				end
				CLS_SYMBOL: begin
					res[n] = '{ST_TOKEN, KIND_SYMBOL, idx[POS_W-1:0], 12'd1, 1'b0};
					n++;
				end
				default: begin
					if (c == CH_NUL) begin
						res[n] = '{ST_END, KIND_NUM, idx[POS_W-1:0], '0, 1'b0};
						n++;
						clear = 1'b1;
					end
				end
			endcase
			lex_next_pos = idx + 1'b1;
		end
		if (clear) begin
			lex_run       = RUN_NONE;
			lex_run_start = '0;
			lex_next_pos  = '0;
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_tokens.push_back(res[i]);
	endtask

	// input monitor feeds the predictor
	always @(posedge clk) begin
		if (arst_n && char_bus.valid && char_bus.ready)
			lex_char(char_bus.char_code);
	end

	always @(posedge clk) begin
		if (arst_n && tok_bus.valid && tok_bus.ready) begin
			if (pending_tokens.size() == 0) begin
				$error("unexpected beat: status %0d kind %0d start %0d len %0d",
					tok_bus.status, tok_bus.token_kind, tok_bus.start_pos, tok_bus.token_len);
				fail_cnt++;
			end else begin
				want = pending_tokens.pop_front();
				if (tok_bus.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, tok_bus.status);
					fail_cnt++;
				end
				if (tok_bus.token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, tok_bus.token_kind);
					fail_cnt++;
				end
				if (tok_bus.start_pos !== want.start) begin
					$error("start_pos: expected %0d, got %0d", want.start, tok_bus.start_pos);
					fail_cnt++;
				end
				if (tok_bus.token_len !== want.len) begin
					$error("token_len: expected %0d, got %0d", want.len, tok_bus.token_len);
					fail_cnt++;
				end
				if (tok_bus.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, tok_bus.last);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		tok_bus.ready = 1'b0;
		hold_served   = 0;
		hold_left     = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				tok_bus.ready <= 1'b0;
			end else begin
				tok_bus.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < tx_idle) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid     <= 1'b1;
		char_bus.char_code <= c;
		do
			@(posedge clk);
		while (!char_bus.ready);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		char_bus.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] rand_digit();
		if ($urandom_range(10) == 10)
			return CH_DOT;
		return 16'h0030 + 16'($urandom_range(9));
	endfunction

	function automatic logic [CHAR_W-1:0] rand_letter();
		case ($urandom_range(4))
			0, 1: return 16'h0041 + 16'($urandom_range(25));
			2, 3: return 16'h0061 + 16'($urandom_range(25));
			default: return CH_APOS;
		endcase
	endfunction

	task automatic send_random_expression();
		int n_tok;
		int pick;
		n_tok = $urandom_range(1, 8);
		repeat (n_tok) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				repeat ($urandom_range(1, 5))
					send_char(rand_digit());
			end else if (pick < 40) begin
				send_char(rand_letter());
				repeat ($urandom_range(0, 4))
					send_char($urandom_range(1) ? rand_letter() : rand_digit());
			end else if (pick < 58) begin
				send_char(OP_SET[$urandom_range(N_OP-1)]);
			end else if (pick < 70) begin
				send_char(BR_SET[$urandom_range(N_BR-1)]);
			end else if (pick < 80) begin
				send_char(SYM_SET[$urandom_range(N_SYM-1)]);
			end else if (pick < 92) begin
				send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
			end else begin
				send_char(16'($urandom_range(16'hFFFF)));
			end
		end
		if ($urandom_range(9) != 0)
			send_char(CH_NUL);
	endtask

	task automatic test_directed();
		logic [CHAR_W-1:0] seq [$];
		seq = '{"0", ".", "9", "Z", "+",
			CH_APOS, "a", "z", ".", "5", CH_SPACE,
			"A", "(", ")", 16'h03C9, "7", 16'h221E, CH_TAB, 16'h2265,
			16'hFFFF, "1", "2", 16'h0080, "q", CH_NUL, CH_NUL, 16'h039B, "}", CH_NUL};
		foreach (seq[i])
			send_char(seq[i]);
	endtask

	task automatic test_random(input int n_chars, input int tx_pct, input int rx_pct);
		int stop_at;
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at)
			send_random_expression();
	endtask

	// receiver stalls while a run of pair-producing chars keeps coming
	task automatic test_backpressure();
		tx_idle = 0;
		rx_idle = 0;
		hold_requests++;
		repeat (30) begin
			send_char("1");
			send_char("*");
		end
		send_char(CH_NUL);
		wait_drained();
	endtask

	initial begin
		arst_n             = 1'b0;
		char_bus.valid     = 1'b0;
		char_bus.char_code = '0;
		lex_run            = RUN_NONE;
		lex_run_start      = '0;
		lex_next_pos       = '0;
		tx_idle            = 30;
		rx_idle            = 64;
		hold_requests      = 0;
		chars_sent         = 0;
		fail_cnt           = 0;
		cycle_cnt          = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(RANDOM_CHARS / 3, 30, 64);
		test_random(RANDOM_CHARS / 3, 64, 30);
		test_random(RANDOM_CHARS / 3, 0, 0);
		test_backpressure();

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
